// ===== hdl/cdrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdrt_pkg;

  // Command codes carried in the op field
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MARKER_MODE = 2'd0;
  localparam logic [1:0] REG_BYTE_SWAP   = 2'd1;
  localparam logic [1:0] REG_ALIGN_BYTES = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;

  // Disc timecode limits
  localparam int unsigned FRAMES_PER_SEC = 75;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned MINS_LIMIT     = 73;
  localparam int unsigned FRAMES_PER_MIN = FRAMES_PER_SEC * SECS_PER_MIN;
  localparam int unsigned SECTOR_LEAD    = 150;
  localparam int unsigned SEEK_ONLY_BIT  = 31;

  // Consecutive marker words needed before transfer
  localparam int unsigned MARKER_RUN = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] dst_start;
    logic [23:0] dst_end;
    logic [31:0] timecode;
    logic [31:0] marker_word;
    logic [4:0]  circ_log2;
    logic [31:0] disc_word;
  } cdrt_in_t;

  typedef struct packed {
    logic               status;
    logic               sector_valid;
    logic signed [19:0] start_sector;
    logic               write_valid;
    logic [23:0]        write_addr;
    logic [31:0]        write_data;
    logic [23:0]        pointer;
    logic               busy_res;
  } cdrt_out_t;

endpackage

`default_nettype wire

// ===== hdl/cd_read_transfer_engine.sv =====
// CD read transfer engine.
// Input channel (in_valid/in_ready/in_data) takes one word per command:
// start read, stop read, disc data word or pointer query. Output channel
// (out_valid/out_ready/out_data) returns exactly one result word for each
// accepted input word, in order.
// The result of an accepted word is registered in the result register.
// Throughput: one word per cycle while the output is not stalled; all
// per-word work (timecode check, sector sum, byte realign and swap, marker
// compare, block end and wrap check) is one pass of logic between the state
// registers and the result register.
// Stall: the result register holds its word while out_ready is low; in_ready
// stays high while that register is empty or being drained in the same
// cycle, so a new word is taken while a finished one is handed off.
// Reset (rst, synchronous): the engine goes idle, all configuration
// registers and transfer state clear and the output register empties.
// Configuration (cfg_we/cfg_index/cfg_data) is written with the engine idle.
`timescale 1ns / 1ps
`default_nettype none

module cd_read_transfer_engine #(
  parameter int ADDR_WIDTH  = 24,
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire cdrt_pkg::cdrt_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output cdrt_pkg::cdrt_out_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [cdrt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cdrt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cdrt_pkg::*;

  localparam int AW              = ADDR_WIDTH;
  localparam int WORDS_PER_BLOCK = BLOCK_BYTES / 4;
  localparam int WIB_W           = $clog2(WORDS_PER_BLOCK);

  // Configuration
  logic       marker_mode;
  logic       byte_swap;
  logic [1:0] align_bytes;

  // Transfer state
  logic             reading, reading_next;
  logic             hunting, hunting_next;
  logic             primed, primed_next;
  logic [4:0]       match_run, match_run_next;
  logic [31:0]      marker_value, marker_value_next;
  logic [AW-1:0]    origin_addr, origin_addr_next;
  logic [AW-1:0]    block_addr, block_addr_next;
  logic [AW-1:0]    limit_addr, limit_addr_next;
  logic [4:0]       wrap_log2, wrap_log2_next;
  logic [WIB_W-1:0] word_in_block, word_in_block_next;
  logic [23:0]      carry_bytes, carry_bytes_next;

  logic      fire;
  cdrt_out_t res;

  // Decode helpers
  logic [7:0]    tc_frames, tc_secs, tc_mins;
  logic          range_bad, tc_bad;
  logic [19:0]   sector_sum;
  logic [AW+23:0] start_ext, end_ext;
  logic [31:0]   aligned_word, shaped_word;
  logic [23:0]   carry_new;
  logic [4:0]    match_inc;
  logic [AW-1:0] word_addr;
  logic [AW+23:0] word_addr_ext, block_addr_ext;
  logic [AW:0]   block_adv;
  logic [AW-1:0] block_wrapped, wrap_diff;
  logic          wrap_on;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // Timecode fields and checks
  assign tc_frames = in_data.timecode[7:0];
  assign tc_secs   = in_data.timecode[15:8];
  assign tc_mins   = in_data.timecode[23:16];
  assign range_bad = (in_data.dst_end <= in_data.dst_start);
  assign tc_bad    = (tc_frames >= 8'(FRAMES_PER_SEC)) || (tc_secs >= 8'(SECS_PER_MIN)) ||
                     (tc_mins >= 8'(MINS_LIMIT));
  assign sector_sum = 20'(tc_mins) * 20'(FRAMES_PER_MIN) + 20'(tc_secs) * 20'(FRAMES_PER_SEC)
                    + 20'(tc_frames);

  assign start_ext = {{AW{1'b0}}, in_data.dst_start};
  assign end_ext   = {{AW{1'b0}}, in_data.dst_end};

  // Realign: join the carried tail of the last word with the head of this one
  always_comb begin
    case (align_bytes)
      2'd1: begin
        aligned_word = {carry_bytes[23:0], in_data.disc_word[31:24]};
        carry_new    = in_data.disc_word[23:0];
      end
      2'd2: begin
        aligned_word = {carry_bytes[15:0], in_data.disc_word[31:16]};
        carry_new    = {8'd0, in_data.disc_word[15:0]};
      end
      2'd3: begin
        aligned_word = {carry_bytes[7:0], in_data.disc_word[31:8]};
        carry_new    = {16'd0, in_data.disc_word[7:0]};
      end
      default: begin
        aligned_word = in_data.disc_word;
        carry_new    = carry_bytes;
      end
    endcase
  end

  // Swap bytes within each 16-bit half
  assign shaped_word = byte_swap ?
    {aligned_word[23:16], aligned_word[31:24], aligned_word[7:0], aligned_word[15:8]} :
    aligned_word;

  assign match_inc = match_run + 5'd1;

  // Destination address of the word and end of block arithmetic
  assign word_addr      = block_addr + AW'({word_in_block, 2'b00});
  assign word_addr_ext  = {24'd0, word_addr};
  assign block_addr_ext = {24'd0, block_addr};
  assign block_adv      = {1'b0, block_addr} + (AW+1)'(BLOCK_BYTES);
  assign block_wrapped  = block_adv[AW-1:0];
  assign wrap_diff      = block_wrapped - origin_addr;
  assign wrap_on        = (wrap_log2 != 5'd0) && ({1'b0, wrap_log2} < 6'(AW));

  // Next state and result for the word at the input
  always_comb begin
    reading_next       = reading;
    hunting_next       = hunting;
    primed_next        = primed;
    match_run_next     = match_run;
    marker_value_next  = marker_value;
    origin_addr_next   = origin_addr;
    block_addr_next    = block_addr;
    limit_addr_next    = limit_addr;
    wrap_log2_next     = wrap_log2;
    word_in_block_next = word_in_block;
    carry_bytes_next   = carry_bytes;
    res                = '0;

    case (in_data.op)
      OP_START: begin
        if (range_bad || tc_bad) begin
          res.status = 1'b1;
        end else if (!in_data.timecode[SEEK_ONLY_BIT]) begin
          res.sector_valid   = 1'b1;
          res.start_sector   = sector_sum - 20'(SECTOR_LEAD);
          reading_next       = 1'b1;
          hunting_next       = marker_mode;
          match_run_next     = '0;
          marker_value_next  = in_data.marker_word;
          origin_addr_next   = start_ext[AW-1:0];
          block_addr_next    = start_ext[AW-1:0];
          limit_addr_next    = end_ext[AW-1:0];
          wrap_log2_next     = marker_mode ? in_data.circ_log2 : 5'd0;
          word_in_block_next = '0;
          carry_bytes_next   = '0;
          primed_next        = 1'b0;
        end
      end
      OP_STOP: begin
        if (reading) begin
          reading_next = 1'b0;
          hunting_next = 1'b0;
        end else begin
          res.status = 1'b1;
        end
      end
      OP_DATA: begin
        if (reading) begin
          if (align_bytes != 2'd0) begin
            primed_next      = 1'b1;
            carry_bytes_next = carry_new;
          end
          // Drop the priming word; otherwise hunt or write
          if (align_bytes == 2'd0 || primed) begin
            if (hunting) begin
              if (shaped_word == marker_value) begin
                if (match_inc >= 5'(MARKER_RUN)) begin
                  hunting_next   = 1'b0;
                  match_run_next = '0;
                end else begin
                  match_run_next = match_inc;
                end
              end else begin
                match_run_next = '0;
              end
            end else begin
              res.write_valid = 1'b1;
              res.write_addr  = word_addr_ext[23:0];
              res.write_data  = shaped_word;
              if (word_in_block == WIB_W'(WORDS_PER_BLOCK - 1)) begin
                word_in_block_next = '0;
                block_addr_next    = block_wrapped;
                if (block_adv > {1'b0, limit_addr}) begin
                  reading_next = 1'b0;
                  hunting_next = 1'b0;
                end else if (wrap_on && ((wrap_diff >> wrap_log2) != '0)) begin
                  block_addr_next = origin_addr;
                end
              end else begin
                word_in_block_next = word_in_block + WIB_W'(1);
              end
            end
          end
        end
      end
      OP_QUERY: begin
        res.pointer = block_addr_ext[23:0];
      end
      default: begin
        res = '0;
      end
    endcase

    res.busy_res = reading_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_mode <= 1'b0;
      byte_swap   <= 1'b0;
      align_bytes <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MARKER_MODE: marker_mode <= cfg_data[0];
        REG_BYTE_SWAP:   byte_swap   <= cfg_data[0];
        REG_ALIGN_BYTES: align_bytes <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance transfer state on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      reading       <= 1'b0;
      hunting       <= 1'b0;
      primed        <= 1'b0;
      match_run     <= '0;
      marker_value  <= '0;
      origin_addr   <= '0;
      block_addr    <= '0;
      limit_addr    <= '0;
      wrap_log2     <= '0;
      word_in_block <= '0;
      carry_bytes   <= '0;
    end else if (fire) begin
      reading       <= reading_next;
      hunting       <= hunting_next;
      primed        <= primed_next;
      match_run     <= match_run_next;
      marker_value  <= marker_value_next;
      origin_addr   <= origin_addr_next;
      block_addr    <= block_addr_next;
      limit_addr    <= limit_addr_next;
      wrap_log2     <= wrap_log2_next;
      word_in_block <= word_in_block_next;
      carry_bytes   <= carry_bytes_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cdrt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdrt_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire cdrt_pkg::cdrt_in_t               in_data,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire cdrt_pkg::cdrt_out_t              out_data
);
  import cdrt_pkg::*;

  // Output empties after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A stop leaves the engine idle in its result
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op == OP_STOP |=> out_valid && !out_data.busy_res)
    else $error("stop did not end the read");

  // A written word either leaves the read busy or carries no status or sector
  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_valid |->
      out_data.busy_res || (!out_data.status && !out_data.sector_valid))
    else $error("write result mixed with other fields");

  a_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_valid |->
      !out_data.status && !out_data.sector_valid && out_data.pointer == 24'd0)
    else $error("write result carries command fields");

endmodule

bind cd_read_transfer_engine cdrt_checker u_cdrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
